// File: src/tvsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvsa_pkg
// Shared types and constants for the thermal video segment assembler.
// ----------------------------------------------------------------------------
package tvsa_pkg;

  // frame geometry and packet format
  localparam int unsigned FrameWidth      = 160;
  localparam int unsigned PacketBytes     = 164;
  localparam int unsigned SegmentCount    = 4;
  localparam int unsigned LinesPerSegment = 60;

  localparam int unsigned HalfWidth    = FrameWidth / 2;
  localparam int unsigned SegmentWords = LinesPerSegment * HalfWidth;

  localparam int unsigned AddrW = 15;
  localparam int unsigned PixW  = 16;

  localparam logic [7:0] SegLine      = 8'd20;
  localparam logic [7:0] LastLine     = 8'(LinesPerSegment - 1);
  localparam logic [7:0] NoLine       = 8'd255;
  localparam logic [7:0] LastByteIdx  = 8'(PacketBytes - 1);
  localparam logic [7:0] PacketBytesC = 8'(PacketBytes);
  localparam logic [7:0] PayloadIdx   = 8'd4;
  localparam logic [3:0] DiscardNib   = 4'hF;
  localparam logic [2:0] FirstSegment = 3'd1;
  localparam logic [3:0] SegCountC    = 4'(SegmentCount);

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_BYTE    = 2'd1,
    MODE_TIMEOUT = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       packet_start;
  } in_t;

  typedef struct packed {
    logic             write_valid;
    logic [AddrW-1:0] pixel_address;
    logic [PixW-1:0]  pixel_value;
    logic             frame_done;
    logic             transfer_ended;
  } out_t;

endpackage

// File: src/thermal_video_segment_assembler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_video_segment_assembler_unit
// Reassembles camera packet bytes into pixel writes of a four-segment frame.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one transaction per link event: a segment start,
//   a packet byte, or a transfer timeout. A transaction is taken at a rising
//   edge where in_valid_i is high and in_stall_o is low.
//   The output channel carries at most one result per input transaction: a
//   pixel write, a frame done flag and/or a transfer ended flag. Events that
//   cause nothing produce no output transaction.
//   The result of a transaction is presented on out_valid_o the cycle after it
//   is taken. Throughput is one transaction per cycle while the receiver does
//   not stall; the per-byte state update and the address math (two constant
//   multiplies and two adds) sit between the input and the output register.
//   When the receiver stalls, the result holds in the output register and
//   in_stall_o is raised until it is taken; new transactions continue as soon
//   as the output register frees up in that same cycle.
//   Reset clears the output valid flag and puts the assembler at segment one,
//   outside any transfer, with no valid region found yet.
// ----------------------------------------------------------------------------
module thermal_video_segment_assembler_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tvsa_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tvsa_pkg::out_t  out_data_o
);

  logic [2:0] current_segment_q, current_segment_d;
  logic       valid_region_q, valid_region_d;
  logic       before_valid_q, before_valid_d;
  logic [7:0] previous_line_q, previous_line_d;
  logic       transfer_active_q, transfer_active_d;
  logic [7:0] byte_position_q, byte_position_d;
  logic       packet_discard_q, packet_discard_d;
  logic [7:0] packet_line_q, packet_line_d;
  logic [3:0] packet_segment_q, packet_segment_d;
  logic [7:0] high_byte_hold_q, high_byte_hold_d;
  logic       copy_enable_q, copy_enable_d;

  logic           out_valid_q, out_valid_d;
  tvsa_pkg::out_t out_data_q, out_data_d;

  logic       in_accept;
  logic       res_valid;
  logic       wv, fd, te;
  logic [7:0] idx;
  logic [7:0] word_idx;
  logic [2:0] seg_base;
  logic [tvsa_pkg::AddrW-1:0] addr;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign seg_base = current_segment_q - 3'd1;
  assign word_idx = (idx - 8'd5) >> 1;
  assign addr = tvsa_pkg::AddrW'(seg_base) * tvsa_pkg::AddrW'(tvsa_pkg::SegmentWords)
              + tvsa_pkg::AddrW'(packet_line_q) * tvsa_pkg::AddrW'(tvsa_pkg::HalfWidth)
              + tvsa_pkg::AddrW'(word_idx);

  always_comb begin
    current_segment_d = current_segment_q;
    valid_region_d    = valid_region_q;
    before_valid_d    = before_valid_q;
    previous_line_d   = previous_line_q;
    transfer_active_d = transfer_active_q;
    byte_position_d   = byte_position_q;
    packet_discard_d  = packet_discard_q;
    packet_line_d     = packet_line_q;
    packet_segment_d  = packet_segment_q;
    high_byte_hold_d  = high_byte_hold_q;
    copy_enable_d     = copy_enable_q;
    wv  = 1'b0;
    fd  = 1'b0;
    te  = 1'b0;
    idx = in_data_i.packet_start ? 8'd0 : byte_position_q;

    if (in_accept) begin
      case (in_data_i.mode)
        tvsa_pkg::MODE_START: begin
          transfer_active_d = 1'b1;
          before_valid_d    = 1'b1;
          previous_line_d   = tvsa_pkg::NoLine;
          byte_position_d   = 8'd0;
          copy_enable_d     = 1'b0;
        end
        tvsa_pkg::MODE_TIMEOUT: begin
          if (transfer_active_q) begin
            transfer_active_d = 1'b0;
            byte_position_d   = 8'd0;
            te                = 1'b1;
          end
        end
        tvsa_pkg::MODE_BYTE: begin
          // continuation bytes need an open packet within its length
          if (transfer_active_q && (in_data_i.packet_start ||
              (byte_position_q != 8'd0 && byte_position_q < tvsa_pkg::PacketBytesC))) begin
            byte_position_d = idx + 8'd1;
            if (idx == 8'd0) begin
              packet_discard_d = in_data_i.data_byte[3:0] == tvsa_pkg::DiscardNib;
              packet_segment_d = in_data_i.data_byte[7:4];
              copy_enable_d    = 1'b0;
              if (in_data_i.data_byte[3:0] == tvsa_pkg::DiscardNib) begin
                byte_position_d = 8'd0;
              end
            end else if (idx == 8'd1) begin
              packet_line_d = in_data_i.data_byte;
              if (in_data_i.data_byte == previous_line_q) begin
                // repeated line closes the transfer
                transfer_active_d = 1'b0;
                byte_position_d   = 8'd0;
                te                = 1'b1;
              end else begin
                if (in_data_i.data_byte == tvsa_pkg::SegLine) begin
                  if (!valid_region_q) begin
                    if (packet_segment_q == 4'd1) begin
                      before_valid_d = 1'b0;
                      valid_region_d = 1'b1;
                    end
                  end else if (packet_segment_q < 4'd2 ||
                               packet_segment_q > tvsa_pkg::SegCountC) begin
                    valid_region_d    = 1'b0;
                    current_segment_d = tvsa_pkg::FirstSegment;
                  end
                end
                copy_enable_d = (before_valid_d | valid_region_d) &&
                                in_data_i.data_byte <= tvsa_pkg::LastLine;
                previous_line_d = in_data_i.data_byte;
              end
            end else if (idx >= tvsa_pkg::PayloadIdx) begin
              if (!idx[0]) begin
                high_byte_hold_d = in_data_i.data_byte;
              end else if (copy_enable_q) begin
                wv = 1'b1;
              end
            end

            if (!te && idx == tvsa_pkg::LastByteIdx) begin
              byte_position_d = 8'd0;
              if (packet_line_d == tvsa_pkg::LastLine) begin
                if (valid_region_d) begin
                  if (current_segment_d < 3'(tvsa_pkg::SegmentCount)) begin
                    current_segment_d = current_segment_d + 3'd1;
                  end else begin
                    fd                = 1'b1;
                    current_segment_d = tvsa_pkg::FirstSegment;
                    valid_region_d    = 1'b0;
                  end
                end
                transfer_active_d = 1'b0;
                te                = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_valid = wv | fd | te;

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    if (in_accept && res_valid) begin
      out_valid_d                = 1'b1;
      out_data_d.write_valid     = wv;
      out_data_d.pixel_address   = wv ? addr : '0;
      out_data_d.pixel_value     = wv ? {high_byte_hold_q, in_data_i.data_byte} : '0;
      out_data_d.frame_done      = fd;
      out_data_d.transfer_ended  = te;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_segment_q <= tvsa_pkg::FirstSegment;
      valid_region_q    <= 1'b0;
      before_valid_q    <= 1'b1;
      previous_line_q   <= tvsa_pkg::NoLine;
      transfer_active_q <= 1'b0;
      byte_position_q   <= 8'd0;
      packet_discard_q  <= 1'b0;
      packet_line_q     <= 8'd0;
      packet_segment_q  <= 4'd0;
      high_byte_hold_q  <= 8'd0;
      copy_enable_q     <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      current_segment_q <= current_segment_d;
      valid_region_q    <= valid_region_d;
      before_valid_q    <= before_valid_d;
      previous_line_q   <= previous_line_d;
      transfer_active_q <= transfer_active_d;
      byte_position_q   <= byte_position_d;
      packet_discard_q  <= packet_discard_d;
      packet_line_q     <= packet_line_d;
      packet_segment_q  <= packet_segment_d;
      high_byte_hold_q  <= high_byte_hold_d;
      copy_enable_q     <= copy_enable_d;
      out_valid_q       <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule
